// ===== sv/yuvrot_pkg.sv =====
package yuvrot_pkg;

  // Fixed formats
  localparam int COEF_FRAC_BITS = 14;
  localparam int TWO_F          = 2 * COEF_FRAC_BITS;
  localparam int MAX_DIM        = 4096;
  localparam int COEF_W         = 16;
  localparam int DIM_W          = 13;
  localparam int CNT_W          = 12;
  localparam int ADDR_W         = 25;
  localparam int PLANE_W        = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int OFS_W          = 30;   // plane offsets and a/b terms, signed
  localparam int RE_W           = 46;   // rotated coordinates, Q(2F), signed
  localparam int MA_W           = 31;   // multiplier operand A, signed
  localparam int MB_W           = 17;   // multiplier operand B, signed
  localparam int PROD_W         = MA_W + MB_W;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS   = 3'd0,
    CFG_SIN   = 3'd1,
    CFG_SRC_W = 3'd2,
    CFG_SRC_H = 3'd3,
    CFG_DST_W = 3'd4,
    CFG_DST_H = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OFS0, S_OFS1, S_OFS2, S_OFS3, S_OFS4,
    S_PIX0, S_PIX1, S_PIX2, S_PIX3, S_PIX4, S_PIX5, S_PIX6, S_PIX7, S_PIX8,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SCX_C, MUL_SCY_S, MUL_SCX_S, MUL_SCY_C,
    MUL_A_C, MUL_B_S, MUL_B_C, MUL_A_S,
    MUL_SRC_SZ, MUL_DST_SZ, MUL_ROW_W, MUL_Y_W
  } mul_sel_t;

  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_OFFR_LD, ACC_OFFR_SUB, ACC_OFFI_LD, ACC_OFFI_ADD,
    ACC_RE_LD, ACC_RE_ADD, ACC_IM_LD, ACC_IM_SUB,
    ACC_SRC_SZ, ACC_DST_SZ, ACC_DST_OFS, ACC_SRC_OFS
  } acc_op_t;

  typedef struct packed {
    logic     start;
    mul_sel_t mul;
    acc_op_t  acc;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic plane_start;
  } dp_sts_t;

endpackage

// ===== sv/yuvrot_ctrl.sv =====
module yuvrot_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  yuvrot_pkg::dp_sts_t  sts,
  output yuvrot_pkg::dp_cmd_t  cmd
);

  yuvrot_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= yuvrot_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.start    = 1'b0;
    cmd.mul      = yuvrot_pkg::MUL_NONE;
    cmd.acc      = yuvrot_pkg::ACC_NONE;
    cmd.load_out = 1'b0;
    unique case (state_r)
      yuvrot_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = sts.plane_start ? yuvrot_pkg::S_OFS0 : yuvrot_pkg::S_PIX0;
        end
      end
      yuvrot_pkg::S_OFS0: begin
        cmd.mul   = yuvrot_pkg::MUL_SCX_C;
        state_nxt = yuvrot_pkg::S_OFS1;
      end
      yuvrot_pkg::S_OFS1: begin
        cmd.mul   = yuvrot_pkg::MUL_SCY_S;
        cmd.acc   = yuvrot_pkg::ACC_OFFR_LD;
        state_nxt = yuvrot_pkg::S_OFS2;
      end
      yuvrot_pkg::S_OFS2: begin
        cmd.mul   = yuvrot_pkg::MUL_SCX_S;
        cmd.acc   = yuvrot_pkg::ACC_OFFR_SUB;
        state_nxt = yuvrot_pkg::S_OFS3;
      end
      yuvrot_pkg::S_OFS3: begin
        cmd.mul   = yuvrot_pkg::MUL_SCY_C;
        cmd.acc   = yuvrot_pkg::ACC_OFFI_LD;
        state_nxt = yuvrot_pkg::S_OFS4;
      end
      yuvrot_pkg::S_OFS4: begin
        cmd.acc   = yuvrot_pkg::ACC_OFFI_ADD;
        state_nxt = yuvrot_pkg::S_PIX0;
      end
      yuvrot_pkg::S_PIX0: begin
        cmd.mul   = yuvrot_pkg::MUL_A_C;
        state_nxt = yuvrot_pkg::S_PIX1;
      end
      yuvrot_pkg::S_PIX1: begin
        cmd.mul   = yuvrot_pkg::MUL_B_S;
        cmd.acc   = yuvrot_pkg::ACC_RE_LD;
        state_nxt = yuvrot_pkg::S_PIX2;
      end
      yuvrot_pkg::S_PIX2: begin
        cmd.mul   = yuvrot_pkg::MUL_B_C;
        cmd.acc   = yuvrot_pkg::ACC_RE_ADD;
        state_nxt = yuvrot_pkg::S_PIX3;
      end
      yuvrot_pkg::S_PIX3: begin
        cmd.mul   = yuvrot_pkg::MUL_A_S;
        cmd.acc   = yuvrot_pkg::ACC_IM_LD;
        state_nxt = yuvrot_pkg::S_PIX4;
      end
      yuvrot_pkg::S_PIX4: begin
        cmd.mul   = yuvrot_pkg::MUL_SRC_SZ;
        cmd.acc   = yuvrot_pkg::ACC_IM_SUB;
        state_nxt = yuvrot_pkg::S_PIX5;
      end
      yuvrot_pkg::S_PIX5: begin
        cmd.mul   = yuvrot_pkg::MUL_DST_SZ;
        cmd.acc   = yuvrot_pkg::ACC_SRC_SZ;
        state_nxt = yuvrot_pkg::S_PIX6;
      end
      yuvrot_pkg::S_PIX6: begin
        cmd.mul   = yuvrot_pkg::MUL_ROW_W;
        cmd.acc   = yuvrot_pkg::ACC_DST_SZ;
        state_nxt = yuvrot_pkg::S_PIX7;
      end
      yuvrot_pkg::S_PIX7: begin
        cmd.mul   = yuvrot_pkg::MUL_Y_W;
        cmd.acc   = yuvrot_pkg::ACC_DST_OFS;
        state_nxt = yuvrot_pkg::S_PIX8;
      end
      yuvrot_pkg::S_PIX8: begin
        cmd.acc   = yuvrot_pkg::ACC_SRC_OFS;
        state_nxt = yuvrot_pkg::S_DONE;
      end
      yuvrot_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = yuvrot_pkg::S_IDLE;
        end
      end
      default: state_nxt = yuvrot_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == yuvrot_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/yuvrot_dp.sv =====
module yuvrot_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  yuvrot_pkg::dp_cmd_t                      cmd,
  output yuvrot_pkg::dp_sts_t                      sts,
  input  logic                                     in_restart,
  input  logic                                     cfg_valid,
  input  logic [yuvrot_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [yuvrot_pkg::COEF_W-1:0]            cfg_data,
  output logic [yuvrot_pkg::ADDR_W-1:0]            out_src_addr,
  output logic [yuvrot_pkg::ADDR_W-1:0]            out_dst_addr,
  output logic                                     out_src_valid,
  output logic [yuvrot_pkg::PLANE_W-1:0]           out_plane,
  output logic                                     out_frame_last
);

  localparam int F      = yuvrot_pkg::COEF_FRAC_BITS;
  localparam int TWO_F  = yuvrot_pkg::TWO_F;
  localparam int DIM_W  = yuvrot_pkg::DIM_W;
  localparam int CNT_W  = yuvrot_pkg::CNT_W;
  localparam int ADDR_W = yuvrot_pkg::ADDR_W;
  localparam int OFS_W  = yuvrot_pkg::OFS_W;
  localparam int RE_W   = yuvrot_pkg::RE_W;
  localparam int MA_W   = yuvrot_pkg::MA_W;
  localparam int MB_W   = yuvrot_pkg::MB_W;
  localparam int PROD_W = yuvrot_pkg::PROD_W;
  localparam int IP_W   = RE_W - TWO_F;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(yuvrot_pkg::MAX_DIM);
  localparam logic [RE_W-1:0]  HALF    = RE_W'(1) << (TWO_F - 1);

  // clamp a size register to the largest supported dimension
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_MAX) ? DIM_MAX : v;
  endfunction

  // {inside, coordinate}: truncation toward zero of (v - 0.5), then bounds
  function automatic logic [DIM_W:0] coord_chk(input logic [RE_W-1:0] t,
                                               input logic [DIM_W-1:0] lim);
    logic [IP_W-1:0]  ip;
    logic             ok;
    logic [DIM_W-1:0] v;
    begin
      ip = t[RE_W-1:TWO_F];
      if (t[RE_W-1]) begin
        // (-1, 0) truncates to zero
        ok = (&ip) && (|t[TWO_F-1:0]) && (lim != '0);
        v  = '0;
      end else begin
        ok = (ip < IP_W'(lim));
        v  = ip[DIM_W-1:0];
      end
      return {ok, v};
    end
  endfunction

  // configuration and walk position
  logic signed [yuvrot_pkg::COEF_W-1:0] cos_r, sin_r;
  logic [DIM_W-1:0]                     sw_r, sh_r, dw_r, dh_r;
  logic [CNT_W-1:0]                     col_r, row_r, col_nxt, row_nxt;
  logic [yuvrot_pkg::PLANE_W-1:0]       pl_r, pl_nxt;

  // arithmetic
  logic signed [OFS_W-1:0]  offr_r, offi_r, offr_nxt, offi_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RE_W-1:0]   re_r, im_r, re_nxt, im_nxt;
  logic [ADDR_W-1:0]        ssz_r, dsz_r, sofs_r, dofs_r;
  logic [ADDR_W-1:0]        ssz_nxt, dsz_nxt, sofs_nxt, dofs_nxt;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;

  // output payload
  logic [ADDR_W-1:0]              src_addr_r, dst_addr_r;
  logic                           src_valid_r, frame_last_r;
  logic [yuvrot_pkg::PLANE_W-1:0] plane_r;

  logic [yuvrot_pkg::PLANE_W-1:0] pl_c;
  logic [DIM_W-1:0]               sw_c, sh_c, dw_c, dh_c;
  logic [DIM_W-1:0]               spw, sph, dpw, dph, dpw_raw, dph_raw;
  logic [CNT_W-1:0]               scx, scy, dcx, dcy;
  logic signed [OFS_W-1:0]        a_s, b_s;
  logic [RE_W-1:0]                t_re, t_im;
  logic [DIM_W:0]                 cx, cy;
  logic                           pix_ok, last_col, last_row;
  logic [ADDR_W:0]                sbase, dbase, src_sum, dst_sum;

  // plane geometry
  always_comb begin
    pl_c = (pl_r > yuvrot_pkg::PLANE_V) ? yuvrot_pkg::PLANE_V : pl_r;
    sw_c = clamp_dim(sw_r);
    sh_c = clamp_dim(sh_r);
    dw_c = clamp_dim(dw_r);
    dh_c = clamp_dim(dh_r);
    if (pl_c == yuvrot_pkg::PLANE_Y) begin
      spw = sw_c;  sph = sh_c;  dpw_raw = dw_c;  dph_raw = dh_c;
    end else begin
      spw = sw_c >> 1;  sph = sh_c >> 1;  dpw_raw = dw_c >> 1;  dph_raw = dh_c >> 1;
    end
    dpw = (dpw_raw == '0) ? DIM_W'(1) : dpw_raw;
    dph = (dph_raw == '0) ? DIM_W'(1) : dph_raw;
    scx = spw[DIM_W-1:1];
    scy = sph[DIM_W-1:1];
    dcx = dpw[DIM_W-1:1];
    dcy = dph[DIM_W-1:1];
  end

  assign sts.plane_start = in_restart || ((col_r == '0) && (row_r == '0));

  assign a_s = OFS_W'({col_r, {F{1'b0}}}) + offr_r;
  assign b_s = OFS_W'({row_r, {F{1'b0}}}) + offi_r;

  assign t_re = re_r - HALF;
  assign t_im = im_r - HALF;
  assign cx   = coord_chk(t_re, spw);
  assign cy   = coord_chk(t_im, sph);
  assign pix_ok = cx[DIM_W] && cy[DIM_W];

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul)
      yuvrot_pkg::MUL_NONE:   begin mul_a = '0;            mul_b = '0;            end
      yuvrot_pkg::MUL_SCX_C:  begin mul_a = MA_W'(scx);    mul_b = MB_W'(cos_r);  end
      yuvrot_pkg::MUL_SCY_S:  begin mul_a = MA_W'(scy);    mul_b = MB_W'(sin_r);  end
      yuvrot_pkg::MUL_SCX_S:  begin mul_a = MA_W'(scx);    mul_b = MB_W'(sin_r);  end
      yuvrot_pkg::MUL_SCY_C:  begin mul_a = MA_W'(scy);    mul_b = MB_W'(cos_r);  end
      yuvrot_pkg::MUL_A_C:    begin mul_a = MA_W'(a_s);    mul_b = MB_W'(cos_r);  end
      yuvrot_pkg::MUL_B_S:    begin mul_a = MA_W'(b_s);    mul_b = MB_W'(sin_r);  end
      yuvrot_pkg::MUL_B_C:    begin mul_a = MA_W'(b_s);    mul_b = MB_W'(cos_r);  end
      yuvrot_pkg::MUL_A_S:    begin mul_a = MA_W'(a_s);    mul_b = MB_W'(sin_r);  end
      yuvrot_pkg::MUL_SRC_SZ: begin mul_a = MA_W'(sw_c);   mul_b = MB_W'(sh_c);   end
      yuvrot_pkg::MUL_DST_SZ: begin mul_a = MA_W'(dw_c);   mul_b = MB_W'(dh_c);   end
      yuvrot_pkg::MUL_ROW_W:  begin mul_a = MA_W'(row_r);  mul_b = MB_W'(dpw);    end
      yuvrot_pkg::MUL_Y_W:    begin mul_a = MA_W'(cy[DIM_W-1:0]); mul_b = MB_W'(spw); end
      default:                begin mul_a = '0;            mul_b = '0;            end
    endcase
  end

  // accumulate the previous cycle's product
  always_comb begin
    offr_nxt = offr_r;
    offi_nxt = offi_r;
    re_nxt   = re_r;
    im_nxt   = im_r;
    ssz_nxt  = ssz_r;
    dsz_nxt  = dsz_r;
    sofs_nxt = sofs_r;
    dofs_nxt = dofs_r;
    unique case (cmd.acc)
      yuvrot_pkg::ACC_NONE:     ;
      yuvrot_pkg::ACC_OFFR_LD:  offr_nxt = OFS_W'(prod_r) - OFS_W'({dcx, {F{1'b0}}});
      yuvrot_pkg::ACC_OFFR_SUB: offr_nxt = offr_r - OFS_W'(prod_r);
      yuvrot_pkg::ACC_OFFI_LD:  offi_nxt = OFS_W'(prod_r) - OFS_W'({dcy, {F{1'b0}}});
      yuvrot_pkg::ACC_OFFI_ADD: offi_nxt = offi_r + OFS_W'(prod_r);
      yuvrot_pkg::ACC_RE_LD:    re_nxt   = RE_W'(prod_r);
      yuvrot_pkg::ACC_RE_ADD:   re_nxt   = re_r + RE_W'(prod_r);
      yuvrot_pkg::ACC_IM_LD:    im_nxt   = RE_W'(prod_r);
      yuvrot_pkg::ACC_IM_SUB:   im_nxt   = im_r - RE_W'(prod_r);
      yuvrot_pkg::ACC_SRC_SZ:   ssz_nxt  = prod_r[ADDR_W-1:0];
      yuvrot_pkg::ACC_DST_SZ:   dsz_nxt  = prod_r[ADDR_W-1:0];
      yuvrot_pkg::ACC_DST_OFS:  dofs_nxt = prod_r[ADDR_W-1:0];
      yuvrot_pkg::ACC_SRC_OFS:  sofs_nxt = prod_r[ADDR_W-1:0];
      default:                  ;
    endcase
  end

  // addresses and walk advance
  always_comb begin
    if (pl_c == yuvrot_pkg::PLANE_Y) begin
      sbase = '0;
      dbase = '0;
    end else if (pl_c == yuvrot_pkg::PLANE_U) begin
      sbase = (ADDR_W+1)'(ssz_r);
      dbase = (ADDR_W+1)'(dsz_r);
    end else begin
      sbase = (ADDR_W+1)'(ssz_r) + (ADDR_W+1)'(ssz_r >> 2);
      dbase = (ADDR_W+1)'(dsz_r) + (ADDR_W+1)'(dsz_r >> 2);
    end
    src_sum  = sbase + (ADDR_W+1)'(sofs_r) + (ADDR_W+1)'(cx[DIM_W-1:0]);
    dst_sum  = dbase + (ADDR_W+1)'(dofs_r) + (ADDR_W+1)'(col_r);
    last_col = ((DIM_W'(col_r) + DIM_W'(1)) >= dpw);
    last_row = ((DIM_W'(row_r) + DIM_W'(1)) >= dph);

    col_nxt = col_r;
    row_nxt = row_r;
    pl_nxt  = pl_r;
    if (cmd.start && in_restart) begin
      col_nxt = '0;
      row_nxt = '0;
      pl_nxt  = yuvrot_pkg::PLANE_Y;
    end else if (cmd.load_out) begin
      if (!last_col) begin
        col_nxt = col_r + CNT_W'(1);
      end else begin
        col_nxt = '0;
        if (!last_row) begin
          row_nxt = row_r + CNT_W'(1);
        end else begin
          row_nxt = '0;
          pl_nxt  = (pl_c >= yuvrot_pkg::PLANE_V) ? yuvrot_pkg::PLANE_Y : pl_c + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= 16'sd16384;
      sin_r <= '0;
      sw_r  <= DIM_W'(352);
      sh_r  <= DIM_W'(288);
      dw_r  <= DIM_W'(288);
      dh_r  <= DIM_W'(352);
      col_r <= '0;
      row_r <= '0;
      pl_r  <= yuvrot_pkg::PLANE_Y;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pl_r  <= pl_nxt;
      if (cfg_valid) begin
        unique case (yuvrot_pkg::cfg_idx_t'(cfg_index))
          yuvrot_pkg::CFG_COS:   cos_r <= cfg_data;
          yuvrot_pkg::CFG_SIN:   sin_r <= cfg_data;
          yuvrot_pkg::CFG_SRC_W: sw_r  <= cfg_data[DIM_W-1:0];
          yuvrot_pkg::CFG_SRC_H: sh_r  <= cfg_data[DIM_W-1:0];
          yuvrot_pkg::CFG_DST_W: dw_r  <= cfg_data[DIM_W-1:0];
          yuvrot_pkg::CFG_DST_H: dh_r  <= cfg_data[DIM_W-1:0];
          default:               ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    offr_r <= offr_nxt;
    offi_r <= offi_nxt;
    re_r   <= re_nxt;
    im_r   <= im_nxt;
    ssz_r  <= ssz_nxt;
    dsz_r  <= dsz_nxt;
    sofs_r <= sofs_nxt;
    dofs_r <= dofs_nxt;
    if (cmd.load_out) begin
      src_addr_r   <= pix_ok ? src_sum[ADDR_W-1:0] : '0;
      dst_addr_r   <= dst_sum[ADDR_W-1:0];
      src_valid_r  <= pix_ok;
      plane_r      <= pl_c;
      frame_last_r <= (pl_c == yuvrot_pkg::PLANE_V) && last_col && last_row;
    end
  end

  assign out_src_addr   = src_addr_r;
  assign out_dst_addr   = dst_addr_r;
  assign out_src_valid  = src_valid_r;
  assign out_plane      = plane_r;
  assign out_frame_last = frame_last_r;

endmodule

// ===== sv/yuv420_rotate_address_generator_core.sv =====
// Requests are served one at a time, with the plane offset steps added at a plane start;
//   the pace is set by the single shared 31x17 multiplier, which carries every product
//   of a pixel in turn.
// Reset: synchronous, active low; walk returns to Y pixel (0,0), config registers take defaults.
// The output register frees the input side: a new request is taken while a result waits.
module yuv420_rotate_address_generator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_restart,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [yuvrot_pkg::ADDR_W-1:0]        out_src_addr,
  output logic [yuvrot_pkg::ADDR_W-1:0]        out_dst_addr,
  output logic                                 out_src_valid,
  output logic [yuvrot_pkg::PLANE_W-1:0]       out_plane,
  output logic                                 out_frame_last,
  // register write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [yuvrot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [yuvrot_pkg::COEF_W-1:0]        cfg_data
);

  yuvrot_pkg::dp_cmd_t cmd;
  yuvrot_pkg::dp_sts_t sts;

  // Registers are always writable; the user must change them only between requests, the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Sequencer: per request it steps the multiplier through the plane offsets
  // (only at pixel (0,0) of a plane or on a restart), the rotated coordinates, the plane sizes
  // and the row products, then waits for the output register to drain.
  yuvrot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: register file, walk counters, shared multiplier with its
  // accumulators, bounds check and address adders, plus the result register.
  yuvrot_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_restart     (in_restart),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_src_addr   (out_src_addr),
    .out_dst_addr   (out_dst_addr),
    .out_src_valid  (out_src_valid),
    .out_plane      (out_plane),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== sv/yuvrot_checker.sv =====
module yuvrot_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [yuvrot_pkg::ADDR_W-1:0]    out_src_addr,
  input logic                             out_src_valid,
  input logic [yuvrot_pkg::PLANE_W-1:0]   out_plane,
  input logic                             out_frame_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src_addr))
    else $error("result changed while stalled");

  // no source pixel means a zero source address
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_src_valid |-> out_src_addr == '0)
    else $error("invalid pixel with non-zero source address");

  // end of frame only in the V plane
  a_last_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_plane == yuvrot_pkg::PLANE_V)
    else $error("frame end outside V plane");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind yuv420_rotate_address_generator_core yuvrot_checker u_chk (.*);
